// ----- rtl/core/gds_pkg.sv -----
// ----------------------------------------------------------------------------
// gds_pkg
// shared types, constants and calendar functions for the date stepper
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam logic [13:0] MAX_YEAR  = 14'd9999;
  localparam logic [13:0] RST_YEAR  = 14'd2012;
  localparam logic [3:0]  RST_MONTH = 4'd11;
  localparam logic [4:0]  RST_DAY   = 5'd2;
  localparam logic        RST_LEAP  = 1'b1;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_DEC31 = 5'd31;

  // reciprocal of 100 scaled by 2^19, exact floor for 14-bit years
  localparam logic [12:0] HUNDRED_RECIP = 13'd5243;
  localparam int          HUNDRED_SHIFT = 19;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_BACK = 2'd2
  } op_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // 0 for a month outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before m of a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/gds_in_if.sv -----
// ----------------------------------------------------------------------------
// gds_in_if
// command channel of the date stepper: load or step items
// ----------------------------------------------------------------------------
interface gds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [15:0] day_count;

  modport source (output valid, output op, output load_year, output load_month,
                  output load_day, output day_count, input ready);
  modport sink   (input valid, input op, input load_year, input load_month,
                  input load_day, input day_count, output ready);
endinterface

// ----- rtl/core/gds_out_if.sv -----
// ----------------------------------------------------------------------------
// gds_out_if
// result channel of the date stepper: current date and status
// ----------------------------------------------------------------------------
interface gds_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [8:0]  day_of_year;
  logic        leap_year;
  logic        load_valid;
  logic        range_error;

  modport source (output valid, output cur_year, output cur_month, output cur_day,
                  output day_of_year, output leap_year, output load_valid,
                  output range_error, input ready);
  modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                  input day_of_year, input leap_year, input load_valid,
                  input range_error, output ready);
endinterface

// ----- rtl/core/gds_leap.sv -----
// ----------------------------------------------------------------------------
// gds_leap
// two-stage leap year test: reciprocal multiply, then 4/100/400 check
// ----------------------------------------------------------------------------
module gds_leap (
  input  logic        clk,
  input  logic [13:0] year_i,
  output logic        leap_o
);

  logic [26:0] prod;
  logic [7:0]  q_nxt;
  logic [7:0]  q_r;
  logic [13:0] year_r;
  logic [14:0] hundred;
  logic        div100;

  assign prod  = {13'd0, year_i} * {14'd0, gds_pkg::HUNDRED_RECIP};
  assign q_nxt = prod[gds_pkg::HUNDRED_SHIFT +: 8];

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    year_r <= year_i;
  end

  // q * 100 as shifts and adds
  assign hundred = {1'b0, q_r, 6'd0} + {2'd0, q_r, 5'd0} + {5'd0, q_r, 2'd0};
  assign div100  = (hundred == {1'b0, year_r});
  assign leap_o  = ((year_r[1:0] == 2'd0) && !div100) || (div100 && (q_r[1:0] == 2'd0));

endmodule

// ----- rtl/core/gds_day_step.sv -----
// ----------------------------------------------------------------------------
// gds_day_step
// one-day forward or backward date step with year limit check
// ----------------------------------------------------------------------------
module gds_day_step (
  input  gds_pkg::date_t cur_i,
  input  logic           leap_i,
  input  logic           back_i,
  output gds_pkg::date_t nxt_o,
  output logic           blocked_o,
  output logic           year_chg_o
);

  logic [4:0] len_cur;
  logic [4:0] len_prev;
  logic [3:0] month_prev;

  assign month_prev = cur_i.month - 4'd1;
  assign len_cur    = gds_pkg::month_len(cur_i.month, leap_i);
  assign len_prev   = gds_pkg::month_len(month_prev, leap_i);

  always_comb begin
    nxt_o      = cur_i;
    blocked_o  = 1'b0;
    year_chg_o = 1'b0;
    if (!back_i) begin
      if (cur_i.day < len_cur) begin
        nxt_o.day = cur_i.day + 5'd1;
      end else if (cur_i.month < gds_pkg::MONTH_DEC) begin
        nxt_o.month = cur_i.month + 4'd1;
        nxt_o.day   = gds_pkg::DAY_FIRST;
      end else if (cur_i.year >= gds_pkg::MAX_YEAR) begin
        blocked_o = 1'b1;
      end else begin
        nxt_o.year  = cur_i.year + 14'd1;
        nxt_o.month = gds_pkg::MONTH_JAN;
        nxt_o.day   = gds_pkg::DAY_FIRST;
        year_chg_o  = 1'b1;
      end
    end else begin
      if (cur_i.day > gds_pkg::DAY_FIRST) begin
        nxt_o.day = cur_i.day - 5'd1;
      end else if (cur_i.month > gds_pkg::MONTH_JAN) begin
        nxt_o.month = month_prev;
        nxt_o.day   = len_prev;
      end else if (cur_i.year <= 14'd1) begin
        blocked_o = 1'b1;
      end else begin
        nxt_o.year  = cur_i.year - 14'd1;
        nxt_o.month = gds_pkg::MONTH_DEC;
        nxt_o.day   = gds_pkg::DAY_DEC31;
        year_chg_o  = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/gregorian_date_stepper.sv -----
// A load passes S_LOAD_WAIT and S_LOAD_CHK to S_DONE; a step runs S_STEP, plus
// S_LEAP_WAIT and S_LEAP_RD for every year boundary crossed (leap recompute).
// One item at a time; the day stepper advances one day a cycle in S_STEP.
// Reset (synchronous, rst_n low): date 2012-11-02, no result pending.
// ----------------------------------------------------------------------------
// gregorian_date_stepper
// holds a Gregorian date, loads it or steps it by a day count
// ----------------------------------------------------------------------------
module gregorian_date_stepper (
  input  logic      clk,
  input  logic      rst_n,
  gds_in_if.sink    in_ch,
  gds_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WAIT,
    S_LOAD_CHK,
    S_STEP,
    S_LEAP_WAIT,
    S_LEAP_RD,
    S_DONE
  } state_t;

  state_t         state_r;
  gds_pkg::date_t date_r;
  gds_pkg::date_t ld_r;
  logic           leap_r;
  logic [15:0]    cnt_r;
  logic           back_r;
  logic           valid_r;
  logic           err_r;

  logic           out_valid_r;
  logic [13:0]    out_year_r;
  logic [3:0]     out_month_r;
  logic [4:0]     out_day_r;
  logic [8:0]     out_doy_r;
  logic           out_leap_r;
  logic           out_ldv_r;
  logic           out_err_r;

  logic [13:0]    leap_year_in;
  logic           leap_res;
  gds_pkg::date_t step_nxt;
  logic           step_blocked;
  logic           step_year_chg;
  logic           ld_ok;
  logic [8:0]     doy;

  assign leap_year_in = (state_r == S_LOAD_WAIT) ? ld_r.year : date_r.year;

  gds_leap u_leap (
    .clk    (clk),
    .year_i (leap_year_in),
    .leap_o (leap_res)
  );

  gds_day_step u_step (
    .cur_i      (date_r),
    .leap_i     (leap_r),
    .back_i     (back_r),
    .nxt_o      (step_nxt),
    .blocked_o  (step_blocked),
    .year_chg_o (step_year_chg)
  );

  assign ld_ok = (ld_r.year >= 14'd1) && (ld_r.year <= gds_pkg::MAX_YEAR) &&
                 (ld_r.day >= gds_pkg::DAY_FIRST) &&
                 (ld_r.day <= gds_pkg::month_len(ld_r.month, leap_res));

  assign doy = gds_pkg::days_before(date_r.month) + {4'd0, date_r.day} +
               {8'd0, leap_r && (date_r.month > gds_pkg::MONTH_FEB)};

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      date_r.year  <= gds_pkg::RST_YEAR;
      date_r.month <= gds_pkg::RST_MONTH;
      date_r.day   <= gds_pkg::RST_DAY;
      leap_r       <= gds_pkg::RST_LEAP;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ld_r.year  <= in_ch.load_year;
            ld_r.month <= in_ch.load_month;
            ld_r.day   <= in_ch.load_day;
            cnt_r      <= in_ch.day_count;
            back_r     <= (in_ch.op == gds_pkg::OP_BACK);
            valid_r    <= 1'b0;
            err_r      <= 1'b0;
            case (in_ch.op)
              gds_pkg::OP_LOAD: state_r <= S_LOAD_WAIT;
              gds_pkg::OP_FWD:  state_r <= S_STEP;
              gds_pkg::OP_BACK: state_r <= S_STEP;
              default:          state_r <= S_DONE;
            endcase
          end
        end
        S_LOAD_WAIT: begin
          state_r <= S_LOAD_CHK;
        end
        S_LOAD_CHK: begin
          if (ld_ok) begin
            date_r  <= ld_r;
            leap_r  <= leap_res;
            valid_r <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_STEP: begin
          if (cnt_r == 16'd0) begin
            state_r <= S_DONE;
          end else if (step_blocked) begin
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            date_r <= step_nxt;
            cnt_r  <= cnt_r - 16'd1;
            if (step_year_chg) begin
              state_r <= S_LEAP_WAIT;
            end
          end
        end
        S_LEAP_WAIT: begin
          state_r <= S_LEAP_RD;
        end
        S_LEAP_RD: begin
          leap_r  <= leap_res;
          state_r <= S_STEP;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_year_r  <= date_r.year;
            out_month_r <= date_r.month;
            out_day_r   <= date_r.day;
            out_doy_r   <= doy;
            out_leap_r  <= leap_r;
            out_ldv_r   <= valid_r;
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cur_year    = out_year_r;
  assign out_ch.cur_month   = out_month_r;
  assign out_ch.cur_day     = out_day_r;
  assign out_ch.day_of_year = out_doy_r;
  assign out_ch.leap_year   = out_leap_r;
  assign out_ch.load_valid  = out_ldv_r;
  assign out_ch.range_error = out_err_r;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for gregorian_date_stepper: directed date loads,
// roll-overs and year-limit cases, then random load and step traffic. A
// calendar predictor builds the expected result for each accepted item. A
// checker compares every returned item against the oldest prediction, field
// by field. The sender works in bursts and the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
    logic        leap;
    logic        valid;
    logic        err;
  } date_result_t;

  logic clk;
  logic rst_n;

  gds_in_if  in_if ();
  gds_out_if out_if ();

  gregorian_date_stepper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predicted calendar state
  logic [13:0]  cal_year;
  logic [3:0]   cal_month;
  logic [4:0]   cal_day;
  date_result_t pending_dates[$];
  int           fail_count;
  int           burst_left;
  logic [11:0]  rx_cycle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic date_result_t compute_next_date(logic [1:0] op, logic [13:0] ly,
                                                     logic [3:0] lm, logic [4:0] ld,
                                                     logic [15:0] cnt);
    date_result_t res;
    int unsigned  y, m, d, k, doy;
    bit           ok, err;
    y   = cal_year;
    m   = cal_month;
    d   = cal_day;
    ok  = 1'b0;
    err = 1'b0;
    case (op)
      gds_pkg::OP_LOAD: begin
        if (ly >= 1 && ly <= gds_pkg::MAX_YEAR && lm >= 1 && lm <= 12 && ld >= 1 &&
            ld <= days_in_month(ly, lm)) begin
          y  = ly;
          m  = lm;
          d  = ld;
          ok = 1'b1;
        end
      end
      gds_pkg::OP_FWD: begin
        for (k = 0; k < cnt; k++) begin
          if (d < days_in_month(y, m)) begin
            d++;
          end else if (m < 12) begin
            m++;
            d = 1;
          end else if (y >= gds_pkg::MAX_YEAR) begin
            err = 1'b1;
            break;
          end else begin
            y++;
            m = 1;
            d = 1;
          end
        end
      end
      gds_pkg::OP_BACK: begin
        for (k = 0; k < cnt; k++) begin
          if (d > 1) begin
            d--;
          end else if (m > 1) begin
            m--;
            d = days_in_month(y, m);
          end else if (y <= 1) begin
            err = 1'b1;
            break;
          end else begin
            y--;
            m = 12;
            d = 31;
          end
        end
      end
      default: ;
    endcase
    doy = d;
    for (k = 1; k < m; k++) doy += days_in_month(y, k);
    cal_year  = 14'(y);
    cal_month = 4'(m);
    cal_day   = 5'(d);
    res.year  = 14'(y);
    res.month = 4'(m);
    res.day   = 5'(d);
    res.doy   = 9'(doy);
    res.leap  = is_leap_year(y);
    res.valid = ok;
    res.err   = err;
    return res;
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [13:0] ly, logic [3:0] lm,
                          logic [4:0] ld, logic [15:0] cnt);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.load_year  <= ly;
    in_if.load_month <= lm;
    in_if.load_day   <= ld;
    in_if.day_count  <= cnt;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_dates.push_back(compute_next_date(op, ly, lm, ld, cnt));
  endtask

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // receiver stall pattern, changes character with rx_cycle[10:9]
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[10:9])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= 1'($urandom_range(0, 1));
      2'd2: out_if.ready <= (rx_cycle % 5) != 0;
      default: out_if.ready <= rx_cycle[3];
    endcase
  end

  always @(posedge clk) begin : result_check
    date_result_t want;
    bit           ok;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %0d-%0d-%0d", $time,
                 out_if.cur_year, out_if.cur_month, out_if.cur_day);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        ok = field_ok("cur_year", want.year, out_if.cur_year);
        ok = field_ok("cur_month", want.month, out_if.cur_month) && ok;
        ok = field_ok("cur_day", want.day, out_if.cur_day) && ok;
        ok = field_ok("day_of_year", want.doy, out_if.day_of_year) && ok;
        ok = field_ok("leap_year", want.leap, out_if.leap_year) && ok;
        ok = field_ok("load_valid", want.valid, out_if.load_valid) && ok;
        ok = field_ok("range_error", want.err, out_if.range_error) && ok;
        if (!ok) fail_count++;
      end
    end
  end

  task automatic test_reset_date();
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'd0);
    send_cmd(OP_NONE, 14'h3fff, 4'hf, 5'h1f, 16'hffff);
  endtask

  task automatic test_load_checks();
    send_cmd(gds_pkg::OP_LOAD, 14'd0, 4'd1, 5'd1, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, gds_pkg::MAX_YEAR, gds_pkg::MONTH_DEC, gds_pkg::DAY_DEC31,
             16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd10000, 4'd1, 5'd1, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'h3fff, 4'hf, 5'h1f, 16'hffff);
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, 4'd0, 5'd1, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, 4'd13, 5'd1, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, 4'd4, 5'd31, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, 4'd4, 5'd0, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd1900, gds_pkg::MONTH_FEB, 5'd29, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, gds_pkg::MONTH_FEB, 5'd29, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2023, gds_pkg::MONTH_FEB, 5'd29, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd2024, gds_pkg::MONTH_FEB, 5'd29, 16'd0);
  endtask

  task automatic test_rollover();
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_LOAD, 14'd2023, 4'd3, gds_pkg::DAY_FIRST, 16'd0);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_LOAD, 14'd2023, gds_pkg::MONTH_DEC, gds_pkg::DAY_DEC31, 16'd0);
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_LOAD, 14'd2023, 4'd5, gds_pkg::DAY_FIRST, 16'd1);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd1);
  endtask

  task automatic test_year_limits();
    send_cmd(gds_pkg::OP_LOAD, gds_pkg::MAX_YEAR, gds_pkg::MONTH_DEC, gds_pkg::DAY_DEC31,
             16'd0);
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'hffff);
    send_cmd(gds_pkg::OP_LOAD, gds_pkg::MAX_YEAR, 4'd6, gds_pkg::DAY_FIRST, 16'd0);
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'd1000);
    send_cmd(gds_pkg::OP_LOAD, 14'd1, gds_pkg::MONTH_JAN, gds_pkg::DAY_FIRST, 16'd0);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd1);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'd0);
    send_cmd(gds_pkg::OP_LOAD, 14'd1, 4'd3, gds_pkg::DAY_FIRST, 16'd0);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'hffff);
  endtask

  task automatic test_long_steps();
    send_cmd(gds_pkg::OP_LOAD, 14'd2000, gds_pkg::MONTH_JAN, gds_pkg::DAY_FIRST, 16'd0);
    send_cmd(gds_pkg::OP_FWD, 14'd0, 4'd0, 5'd0, 16'hffff);
    send_cmd(gds_pkg::OP_BACK, 14'd0, 4'd0, 5'd0, 16'hffff);
  endtask

  task automatic test_random_traffic();
    int unsigned special_years[10] = '{1, 2, 4, 100, 400, 1900, 2000, 2100, 9996, 9999};
    int unsigned sel, ysel, csel, ry, rm, rd, rc, cnt;
    for (int n = 0; n < 700; n++) begin
      sel = $urandom_range(0, 99);
      ry  = $urandom_range(0, 16383);
      rm  = $urandom_range(0, 15);
      rd  = $urandom_range(0, 31);
      rc  = $urandom_range(0, 65535);
      csel = $urandom_range(0, 99);
      if (csel < 80) cnt = $urandom_range(0, 63);
      else if (csel < 95) cnt = $urandom_range(64, 1023);
      else cnt = $urandom_range(1024, 4095);
      if (sel < 30) begin
        // well-formed date, often near a year limit or on a century
        ysel = $urandom_range(0, 9);
        if (ysel < 6) ry = $urandom_range(1, gds_pkg::MAX_YEAR);
        else if (ysel < 8) ry = special_years[$urandom_range(0, 9)];
        else if (ysel == 8) ry = $urandom_range(1, 30);
        else ry = $urandom_range(gds_pkg::MAX_YEAR - 29, gds_pkg::MAX_YEAR);
        rm = $urandom_range(1, 12);
        rd = $urandom_range(1, days_in_month(ry, rm));
        send_cmd(gds_pkg::OP_LOAD, 14'(ry), 4'(rm), 5'(rd), 16'(rc));
      end else if (sel < 38) begin
        send_cmd(gds_pkg::OP_LOAD, 14'(ry), 4'(rm), 5'(rd), 16'(rc));
      end else if (sel < 94) begin
        send_cmd((sel % 2) ? gds_pkg::OP_FWD : gds_pkg::OP_BACK, 14'(ry), 4'(rm), 5'(rd),
                 16'(cnt));
      end else begin
        send_cmd(OP_NONE, 14'(ry), 4'(rm), 5'(rd), 16'(rc));
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = gds_pkg::OP_LOAD;
    in_if.load_year  = '0;
    in_if.load_month = '0;
    in_if.load_day   = '0;
    in_if.day_count  = '0;
    out_if.ready     = 1'b0;
    rx_cycle         = '0;
    fail_count       = 0;
    burst_left       = 0;
    cal_year         = gds_pkg::RST_YEAR;
    cal_month        = gds_pkg::RST_MONTH;
    cal_day          = gds_pkg::RST_DAY;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_date();
    test_load_checks();
    test_rollover();
    test_year_limits();
    test_long_steps();
    test_random_traffic();
    in_if.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/gds_pkg.sv
rtl/core/gds_in_if.sv
rtl/core/gds_out_if.sv
rtl/core/gds_leap.sv
rtl/core/gds_day_step.sv
rtl/core/gregorian_date_stepper.sv
verif/testbench.sv
